// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every rising edge outside reset.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ysfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ysfc_pkg;

  localparam int STREAM_SLOTS   = 64;
  localparam int SLOT_W         = $clog2(STREAM_SLOTS);
  localparam int MAX_DATA_LEN   = 65535;
  localparam int MIN_ADDR_BYTES = 7;

  localparam int FLAG_SYN = 0;
  localparam int FLAG_ACK = 1;
  localparam int FLAG_FIN = 2;
  localparam int FLAG_RST = 3;

  localparam logic [3:0] FL_NONE = 4'h0;
  localparam logic [3:0] FL_ACK  = 4'h2;
  localparam logic [3:0] FL_FIN  = 4'h4;
  localparam logic [3:0] FL_RST  = 4'h8;

  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_SEND    = 2'd1,
    CMD_OUTCOME = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_WU     = 2'd1,
    KIND_PING   = 2'd2,
    KIND_GOAWAY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_EMIT     = 3'd0,
    ACT_DELIVER  = 3'd1,
    ACT_HALF     = 3'd2,
    ACT_RESET    = 3'd3,
    ACT_CREDIT   = 3'd4,
    ACT_BLOCKED  = 3'd5,
    ACT_ACTIVATE = 3'd6,
    ACT_CLOSED   = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    PH_PEND = 2'd0,
    PH_CONN = 2'd1,
    PH_OPEN = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    REG_STREAM_LIMIT   = 2'd0,
    REG_INITIAL_CREDIT = 2'd1,
    REG_PING_REPLY_ON  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    OC_SUCCESS = 2'd0,
    OC_FAILURE = 2'd1,
    OC_MORE    = 2'd2
  } oc_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  frame_kind;
    logic [3:0]  frame_flags;
    logic [31:0] stream_number;
    logic [31:0] frame_len;
    logic [1:0]  outcome;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  out_kind;
    logic [3:0]  out_flags;
    logic [31:0] out_stream;
    logic [31:0] out_len;
    logic        status_byte;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] strm;
    logic [1:0]  phase;
    logic [31:0] credit;
    logic [31:0] cons;
    logic [31:0] pend;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic scan_cmp;
    logic exec;
    logic emit_sel;
  } ctl_t;

  typedef struct packed {
    logic          session_open;
    logic          scan_last;
    logic [1:0]    exec_n;
    logic [1:0]    nres;
    logic [SLOT_W:0] used_cnt;
  } stat_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic out_item_t mk_res(input act_t act, input kind_t kind,
                                       input logic [3:0] fl, input logic [31:0] strm,
                                       input logic [31:0] len, input logic st);
    out_item_t r;
    r.action      = act;
    r.out_kind    = kind;
    r.out_flags   = fl;
    r.out_stream  = strm;
    r.out_len     = len;
    r.status_byte = st;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ysfc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ysfc_datapath
  import ysfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_item_t    in_item,
  input  wire ctl_t        ctl,
  output stat_t            stat,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output out_item_t        out_item
);

  entry_t mem [STREAM_SLOTS];

  in_item_t          item_r;
  entry_t            rdata_r;
  logic [SLOT_W-1:0] idx_r, fidx_r, free_idx_r;
  logic              found_r, free_ok_r;
  logic [STREAM_SLOTS-1:0] used_r;
  logic [SLOT_W:0]   cnt_r;
  logic              sess_r;
  logic [6:0]        lim_cfg_r;
  logic [31:0]       init_r;
  logic              ping_r;
  out_item_t         res0_r, res1_r;
  logic [1:0]        nres_r;

  logic        match;
  logic [SLOT_W:0] lim;
  logic [31:0] half, len, strm;
  logic [31:0] total, newpend, newcredit;
  logic        wu_hit, act_hit, full;
  logic [3:0]  fl;
  out_item_t   r0, r1;
  logic [1:0]  n;
  logic        we, alloc, clr, close;
  entry_t      went;
  logic [SLOT_W-1:0] widx;

  assign cfg_ready = 1'b1;

  assign match = used_r[idx_r] && (rdata_r.strm == item_r.stream_number);

  assign stat.session_open = sess_r;
  assign stat.scan_last    = match || (idx_r == SLOT_W'(STREAM_SLOTS - 1));
  assign stat.exec_n       = n;
  assign stat.nres         = nres_r;
  assign stat.used_cnt     = cnt_r;

  assign out_item = ctl.emit_sel ? res1_r : res0_r;

  assign lim  = ({1'b0, lim_cfg_r} < 8'(STREAM_SLOTS)) ? (SLOT_W+1)'(lim_cfg_r)
                                                       : (SLOT_W+1)'(STREAM_SLOTS);
  assign full = cnt_r >= lim;
  assign half = init_r >> 1;
  assign len  = item_r.frame_len;
  assign strm = item_r.stream_number;
  assign fl   = item_r.frame_flags;

  assign total     = sat_add(rdata_r.cons, len);
  assign wu_hit    = (len != 32'd0) && (total >= half);
  assign newpend   = sat_add(rdata_r.pend, len);
  assign act_hit   = (rdata_r.phase == PH_PEND) && (newpend >= 32'(MIN_ADDR_BYTES));
  assign newcredit = sat_add(rdata_r.credit, len);
  assign widx      = alloc ? free_idx_r : fidx_r;

  // Decision for one item, from the scan result and the matching entry.
  always_comb begin
    r0    = mk_res(ACT_EMIT, KIND_DATA, FL_NONE, 32'd0, 32'd0, 1'b0);
    r1    = r0;
    n     = 2'd0;
    we    = 1'b0;
    alloc = 1'b0;
    clr   = 1'b0;
    close = 1'b0;
    went  = rdata_r;
    case (cmd_t'(item_r.command))
      CMD_FRAME: begin
        case (kind_t'(item_r.frame_kind))
          KIND_DATA: begin
            if (len > 32'(MAX_DATA_LEN)) begin
              r0 = mk_res(ACT_EMIT, KIND_GOAWAY, FL_NONE, 32'd0, 32'd1, 1'b0);
              r1 = mk_res(ACT_CLOSED, KIND_DATA, FL_NONE, 32'd0, 32'd0, 1'b0);
              n = 2'd2;
              close = 1'b1;
            end else if (fl[FLAG_SYN]) begin
              if (full) begin
                r0 = mk_res(ACT_EMIT, KIND_WU, FL_RST, strm, 32'd0, 1'b0);
                n = 2'd1;
              end else if (!found_r && free_ok_r) begin
                alloc = 1'b1;
                we = 1'b1;
                went.strm = strm;
                went.credit = init_r;
                went.cons = 32'd0;
                went.pend = len;
                went.phase = (len >= 32'(MIN_ADDR_BYTES)) ? PH_CONN : PH_PEND;
                r0 = mk_res(ACT_EMIT, KIND_WU, FL_ACK, strm, init_r, 1'b0);
                r1 = mk_res(ACT_ACTIVATE, KIND_DATA, FL_NONE, strm, 32'd0, 1'b0);
                n = (len >= 32'(MIN_ADDR_BYTES)) ? 2'd2 : 2'd1;
              end
            end else if (fl[FLAG_RST]) begin
              if (found_r) begin
                clr = 1'b1;
                if (rdata_r.phase == PH_OPEN) begin
                  r0 = mk_res(ACT_RESET, KIND_DATA, FL_NONE, strm, 32'd0, 1'b0);
                  n = 2'd1;
                end
              end
            end else if (fl[FLAG_FIN]) begin
              if (found_r) begin
                if (rdata_r.phase == PH_OPEN) begin
                  r0 = mk_res(ACT_HALF, KIND_DATA, FL_NONE, strm, 32'd0, 1'b0);
                  n = 2'd1;
                end else begin
                  clr = 1'b1;
                end
              end
            end else if (!found_r) begin
              r0 = mk_res(ACT_EMIT, KIND_WU, FL_RST, strm, 32'd0, 1'b0);
              n = 2'd1;
            end else begin
              we = 1'b1;
              if (len != 32'd0) went.cons = wu_hit ? 32'd0 : total;
              if (rdata_r.phase == PH_OPEN) begin
                r1 = mk_res(ACT_DELIVER, KIND_DATA, FL_NONE, strm, len, 1'b0);
                if (wu_hit) begin
                  r0 = mk_res(ACT_EMIT, KIND_WU, FL_NONE, strm, total, 1'b0);
                  n = 2'd2;
                end else begin
                  r0 = r1;
                  n = 2'd1;
                end
              end else begin
                went.pend = newpend;
                if (act_hit) went.phase = PH_CONN;
                if (act_hit) begin
                  r0 = mk_res(ACT_ACTIVATE, KIND_DATA, FL_NONE, strm, 32'd0, 1'b0);
                  r1 = mk_res(ACT_EMIT, KIND_WU, FL_NONE, strm, total, 1'b0);
                  n = wu_hit ? 2'd2 : 2'd1;
                end else if (wu_hit) begin
                  r0 = mk_res(ACT_EMIT, KIND_WU, FL_NONE, strm, total, 1'b0);
                  n = 2'd1;
                end
              end
            end
          end
          KIND_WU: begin
            if (strm == 32'd0) begin
              n = 2'd0;
            end else if (fl[FLAG_RST]) begin
              if (found_r) begin
                clr = 1'b1;
                if (rdata_r.phase == PH_OPEN) begin
                  r0 = mk_res(ACT_RESET, KIND_DATA, FL_NONE, strm, 32'd0, 1'b0);
                  n = 2'd1;
                end
              end
            end else if (fl[FLAG_FIN]) begin
              if (found_r) begin
                if (rdata_r.phase == PH_OPEN) begin
                  r0 = mk_res(ACT_HALF, KIND_DATA, FL_NONE, strm, 32'd0, 1'b0);
                  n = 2'd1;
                end else begin
                  clr = 1'b1;
                end
              end
            end else if (fl[FLAG_SYN]) begin
              if (!fl[FLAG_ACK]) begin
                if (full) begin
                  r0 = mk_res(ACT_EMIT, KIND_WU, FL_RST, strm, 32'd0, 1'b0);
                  n = 2'd1;
                end else if (!found_r && free_ok_r) begin
                  alloc = 1'b1;
                  we = 1'b1;
                  went.strm = strm;
                  went.phase = PH_PEND;
                  went.credit = (len != 32'd0) ? len : init_r;
                  went.cons = 32'd0;
                  went.pend = 32'd0;
                  r0 = mk_res(ACT_EMIT, KIND_WU, FL_ACK, strm, init_r, 1'b0);
                  n = 2'd1;
                end
              end
            end else if (found_r && len != 32'd0) begin
              we = 1'b1;
              went.credit = newcredit;
              r0 = mk_res(ACT_CREDIT, KIND_DATA, FL_NONE, strm, newcredit, 1'b0);
              n = 2'd1;
            end
          end
          KIND_PING: begin
            if (fl[FLAG_SYN] && ping_r) begin
              r0 = mk_res(ACT_EMIT, KIND_PING, FL_ACK, 32'd0, len, 1'b0);
              n = 2'd1;
            end
          end
          default: begin
            r0 = mk_res(ACT_CLOSED, KIND_DATA, FL_NONE, 32'd0, 32'd0, 1'b0);
            n = 2'd1;
            close = 1'b1;
          end
        endcase
      end
      CMD_SEND: begin
        n = 2'd1;
        if (found_r && rdata_r.credit < len) begin
          r0 = mk_res(ACT_BLOCKED, KIND_DATA, FL_NONE, strm, len, 1'b0);
        end else begin
          r0 = mk_res(ACT_EMIT, KIND_DATA, FL_NONE, strm, len, 1'b0);
          if (found_r) begin
            we = 1'b1;
            went.credit = rdata_r.credit - len;
          end
        end
      end
      CMD_OUTCOME: begin
        if (found_r && rdata_r.phase == PH_CONN) begin
          if (item_r.outcome == OC_MORE) begin
            we = 1'b1;
            went.phase = PH_PEND;
          end else if (item_r.outcome == OC_SUCCESS || item_r.outcome == OC_FAILURE) begin
            if (rdata_r.credit == 32'd0) begin
              r0 = mk_res(ACT_BLOCKED, KIND_DATA, FL_NONE, strm, 32'd1, 1'b0);
              n = 2'd1;
            end else begin
              we = 1'b1;
              went.credit = rdata_r.credit - 32'd1;
              r0 = mk_res(ACT_EMIT, KIND_DATA, FL_NONE, strm, 32'd1, item_r.outcome[0]);
              if (item_r.outcome == OC_SUCCESS) begin
                went.phase = PH_OPEN;
                n = 2'd1;
              end else begin
                r1 = mk_res(ACT_EMIT, KIND_DATA, FL_FIN, strm, 32'd0, 1'b0);
                n = 2'd2;
                clr = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        if (found_r) begin
          if (item_r.outcome == 2'd0) begin
            if (rdata_r.phase != PH_OPEN) begin
              clr = 1'b1;
              r0 = mk_res(ACT_EMIT, KIND_WU, FL_RST, strm, 32'd0, 1'b0);
              n = 2'd1;
            end
          end else if (item_r.outcome == 2'd1) begin
            clr = 1'b1;
          end
        end
      end
    endcase
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_rd) rdata_r <= mem[idx_r];
    if (ctl.exec && we) mem[widx] <= went;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) item_r <= in_item;
    if (ctl.exec) begin
      res0_r <= r0;
      res1_r <= r1;
    end
    if (ctl.scan_cmp) begin
      if (match) fidx_r <= idx_r;
      if (!used_r[idx_r] && !free_ok_r) free_idx_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      found_r   <= 1'b0;
      free_ok_r <= 1'b0;
      used_r    <= '0;
      cnt_r     <= '0;
      sess_r    <= 1'b1;
      lim_cfg_r <= 7'd64;
      init_r    <= 32'd262144;
      ping_r    <= 1'b1;
      nres_r    <= 2'd0;
    end else begin
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_STREAM_LIMIT:   lim_cfg_r <= cfg_data[6:0];
          REG_INITIAL_CREDIT: init_r    <= cfg_data;
          REG_PING_REPLY_ON:  ping_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (ctl.load) begin
        idx_r     <= '0;
        found_r   <= 1'b0;
        free_ok_r <= 1'b0;
      end
      if (ctl.scan_cmp) begin
        if (match) found_r <= 1'b1;
        if (!used_r[idx_r]) free_ok_r <= 1'b1;
        if (!match) idx_r <= idx_r + 1'b1;
      end
      if (ctl.exec) begin
        nres_r <= n;
        if (close) begin
          used_r <= '0;
          cnt_r  <= '0;
          sess_r <= 1'b0;
        end else if (alloc) begin
          used_r[free_idx_r] <= 1'b1;
          cnt_r <= cnt_r + 1'b1;
        end else if (clr) begin
          used_r[fidx_r] <= 1'b0;
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ysfc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ysfc_ctrl
  import ysfc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire stat_t stat,
  output ctl_t       ctl,
  output logic       out_valid
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_EXEC, S_EMIT0, S_EMIT1
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   sel_r, sel_nxt;

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign ctl.load      = (state_r == S_IDLE) && start;
  assign ctl.scan_rd   = (state_r == S_SCAN_RD);
  assign ctl.scan_cmp  = (state_r == S_SCAN_CMP);
  assign ctl.exec      = (state_r == S_EXEC);
  assign ctl.emit_sel  = sel_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    sel_nxt       = 1'b0;
    case (state_r)
      S_IDLE: begin
        // A closed session takes the word and answers nothing.
        if (start && stat.session_open) state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = stat.scan_last ? S_EXEC : S_SCAN_RD;
      S_EXEC: begin
        if (stat.exec_n != 2'd0) begin
          state_nxt     = S_EMIT0;
          out_valid_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT0: begin
        if (stat.nres == 2'd2) begin
          state_nxt     = S_EMIT1;
          out_valid_nxt = 1'b1;
          sel_nxt       = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT1: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/yamux_stream_flow_control.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake                 Payload
// input     start / busy              in_item (in_item_t)
// result    out_valid (strobe)        out_item (out_item_t)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// With the session open, an item scans the table slot by slot (S_SCAN_RD, then
// S_SCAN_CMP) up to the match, or over all 64 slots if none matches; S_EXEC then
// updates and S_EMIT0/S_EMIT1 send the result words, no new item being taken
// meanwhile. Reset is synchronous, active low, and clears all slots at once.
// Results are strobed for one cycle each; the receiver cannot stall them.
`include "assert_macros.svh"
module yamux_stream_flow_control
  import ysfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  ctl_t  ctl;
  stat_t stat;

  ysfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .stat      (stat),
    .ctl       (ctl),
    .out_valid (out_valid)
  );

  ysfc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .ctl       (ctl),
    .stat      (stat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

  `ASSERT_NOW(a_out_busy, out_valid, busy)
  `ASSERT_NEXT(a_second_word, out_valid && !out_item.last, out_valid && out_item.last)
  `ASSERT_NOW(a_cnt_range, 1'b1, stat.used_cnt <= (SLOT_W+1)'(STREAM_SLOTS))

endmodule
`default_nettype wire

// ===== tb/ysfc_checker.sv =====
`timescale 1ns / 1ps
module ysfc_checker
  import ysfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  out_item_t   out_item,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_words
);

  logic        slot_busy  [STREAM_SLOTS];
  logic [31:0] slot_id    [STREAM_SLOTS];
  phase_t      slot_ph    [STREAM_SLOTS];
  logic [31:0] tx_credit  [STREAM_SLOTS];
  logic [31:0] rx_used    [STREAM_SLOTS];
  logic [31:0] addr_bytes [STREAM_SLOTS];
  logic        sess_up;
  logic [6:0]  lim_reg;
  logic [31:0] window_reg;
  logic        ping_on;

  out_item_t   words_due [$];
  out_item_t   step_buf [2];
  int          step_cnt;

  initial fail_count = 0;

  function automatic logic [31:0] add_clip(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void push_word(act_t a, kind_t k, logic [3:0] f, logic [31:0] s,
                                    logic [31:0] l, logic st);
    out_item_t w;
    w.action = a;
    w.out_kind = k;
    w.out_flags = f;
    w.out_stream = s;
    w.out_len = l;
    w.status_byte = st;
    w.last = 1'b0;
    if (step_cnt < 2) step_buf[step_cnt] = w;
    step_cnt++;
  endfunction

  function automatic int lookup(logic [31:0] s);
    for (int i = 0; i < STREAM_SLOTS; i++)
      if (slot_busy[i] && slot_id[i] == s) return i;
    return -1;
  endfunction

  function automatic int occupancy();
    int c;
    c = 0;
    for (int i = 0; i < STREAM_SLOTS; i++) c += slot_busy[i];
    return c;
  endfunction

  function automatic void drop_session();
    for (int i = 0; i < STREAM_SLOTS; i++) slot_busy[i] = 1'b0;
    sess_up = 1'b0;
  endfunction

  // The limit test comes before the duplicate test, so a duplicate SYN on a
  // full table is still rejected.
  function automatic int admit_stream(logic [31:0] s);
    int lim;
    lim = (lim_reg < STREAM_SLOTS) ? lim_reg : STREAM_SLOTS;
    if (occupancy() >= lim) begin
      push_word(ACT_EMIT, KIND_WU, FL_RST, s, 0, 0);
      return -1;
    end
    if (lookup(s) >= 0) return -1;
    for (int i = 0; i < STREAM_SLOTS; i++)
      if (!slot_busy[i]) begin
        slot_busy[i] = 1'b1;
        slot_id[i] = s;
        slot_ph[i] = PH_PEND;
        tx_credit[i] = window_reg;
        rx_used[i] = 0;
        addr_bytes[i] = 0;
        return i;
      end
    return -1;
  endfunction

  function automatic void maybe_activate(int i);
    if (slot_ph[i] == PH_PEND && addr_bytes[i] >= MIN_ADDR_BYTES) begin
      slot_ph[i] = PH_CONN;
      push_word(ACT_ACTIVATE, KIND_DATA, FL_NONE, slot_id[i], 0, 0);
    end
  endfunction

  function automatic void consume_window(int i, logic [31:0] len);
    logic [31:0] total;
    if (len == 0) return;
    total = add_clip(rx_used[i], len);
    if (total >= (window_reg >> 1)) begin
      rx_used[i] = 0;
      push_word(ACT_EMIT, KIND_WU, FL_NONE, slot_id[i], total, 0);
    end else begin
      rx_used[i] = total;
    end
  endfunction

  function automatic void rst_stream(logic [31:0] s);
    int i;
    i = lookup(s);
    if (i < 0) return;
    if (slot_ph[i] == PH_OPEN) push_word(ACT_RESET, KIND_DATA, FL_NONE, s, 0, 0);
    slot_busy[i] = 1'b0;
  endfunction

  function automatic void fin_stream(logic [31:0] s);
    int i;
    i = lookup(s);
    if (i < 0) return;
    if (slot_ph[i] == PH_OPEN) push_word(ACT_HALF, KIND_DATA, FL_NONE, s, 0, 0);
    else slot_busy[i] = 1'b0;
  endfunction

  function automatic void do_frame(in_item_t it);
    logic [3:0]  fl;
    logic [31:0] s;
    logic [31:0] len;
    int          i;
    fl = it.frame_flags;
    s = it.stream_number;
    len = it.frame_len;
    case (kind_t'(it.frame_kind))
      KIND_DATA: begin
        if (len > MAX_DATA_LEN) begin
          push_word(ACT_EMIT, KIND_GOAWAY, FL_NONE, 0, 1, 0);
          push_word(ACT_CLOSED, KIND_DATA, FL_NONE, 0, 0, 0);
          drop_session();
        end else if (fl[FLAG_SYN]) begin
          i = admit_stream(s);
          if (i >= 0) begin
            addr_bytes[i] = len;
            push_word(ACT_EMIT, KIND_WU, FL_ACK, s, window_reg, 0);
            maybe_activate(i);
          end
        end else if (fl[FLAG_RST]) begin
          rst_stream(s);
        end else if (fl[FLAG_FIN]) begin
          fin_stream(s);
        end else begin
          i = lookup(s);
          if (i < 0) begin
            push_word(ACT_EMIT, KIND_WU, FL_RST, s, 0, 0);
          end else if (slot_ph[i] == PH_OPEN) begin
            consume_window(i, len);
            push_word(ACT_DELIVER, KIND_DATA, FL_NONE, s, len, 0);
          end else begin
            addr_bytes[i] = add_clip(addr_bytes[i], len);
            maybe_activate(i);
            consume_window(i, len);
          end
        end
      end
      KIND_WU: begin
        if (s == 0) return;
        if (fl[FLAG_RST]) rst_stream(s);
        else if (fl[FLAG_FIN]) fin_stream(s);
        else if (fl[FLAG_SYN]) begin
          if (fl[FLAG_ACK]) return;
          i = admit_stream(s);
          if (i >= 0) begin
            tx_credit[i] = (len != 0) ? len : window_reg;
            push_word(ACT_EMIT, KIND_WU, FL_ACK, s, window_reg, 0);
          end
        end else begin
          i = lookup(s);
          if (i >= 0 && len != 0) begin
            tx_credit[i] = add_clip(tx_credit[i], len);
            push_word(ACT_CREDIT, KIND_DATA, FL_NONE, s, tx_credit[i], 0);
          end
        end
      end
      KIND_PING: begin
        if (fl[FLAG_SYN] && ping_on) push_word(ACT_EMIT, KIND_PING, FL_ACK, 0, len, 0);
      end
      default: begin
        push_word(ACT_CLOSED, KIND_DATA, FL_NONE, 0, 0, 0);
        drop_session();
      end
    endcase
  endfunction

  function automatic void do_send(logic [31:0] s, logic [31:0] len);
    int i;
    i = lookup(s);
    if (i >= 0) begin
      if (tx_credit[i] < len) begin
        push_word(ACT_BLOCKED, KIND_DATA, FL_NONE, s, len, 0);
        return;
      end
      tx_credit[i] -= len;
    end
    push_word(ACT_EMIT, KIND_DATA, FL_NONE, s, len, 0);
  endfunction

  // The status frame costs one byte of credit; short of it, the stream stays
  // waiting for the outcome to be repeated.
  function automatic void do_outcome(logic [31:0] s, logic [1:0] oc);
    int i;
    i = lookup(s);
    if (i < 0 || slot_ph[i] != PH_CONN) return;
    if (oc == OC_MORE) begin
      slot_ph[i] = PH_PEND;
      return;
    end
    if (oc != OC_SUCCESS && oc != OC_FAILURE) return;
    if (tx_credit[i] == 0) begin
      push_word(ACT_BLOCKED, KIND_DATA, FL_NONE, s, 1, 0);
      return;
    end
    tx_credit[i] -= 1;
    push_word(ACT_EMIT, KIND_DATA, FL_NONE, s, 1, oc[0]);
    if (oc == OC_SUCCESS) begin
      slot_ph[i] = PH_OPEN;
    end else begin
      push_word(ACT_EMIT, KIND_DATA, FL_FIN, s, 0, 0);
      slot_busy[i] = 1'b0;
    end
  endfunction

  function automatic void do_release(logic [31:0] s, logic [1:0] oc);
    int i;
    i = lookup(s);
    if (i < 0) return;
    if (oc == OC_SUCCESS) begin
      if (slot_ph[i] != PH_OPEN) begin
        slot_busy[i] = 1'b0;
        push_word(ACT_EMIT, KIND_WU, FL_RST, s, 0, 0);
      end
    end else if (oc == OC_FAILURE) begin
      slot_busy[i] = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < STREAM_SLOTS; i++) slot_busy[i] = 1'b0;
      sess_up = 1'b1;
      lim_reg = 7'd64;
      window_reg = 32'd262144;
      ping_on = 1'b1;
      words_due.delete();
    end else begin
      if (out_valid) begin
        if (words_due.size() == 0) begin
          $error("result word with none expected: action %0d stream %0h",
                 out_item.action, out_item.out_stream);
          fail_count++;
        end else begin
          want = words_due.pop_front();
          check_field("action", want.action, out_item.action);
          check_field("out_kind", want.out_kind, out_item.out_kind);
          check_field("out_flags", want.out_flags, out_item.out_flags);
          check_field("out_stream", want.out_stream, out_item.out_stream);
          check_field("out_len", want.out_len, out_item.out_len);
          check_field("status_byte", want.status_byte, out_item.status_byte);
          check_field("last", want.last, out_item.last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_STREAM_LIMIT:   lim_reg = cfg_data[6:0];
          REG_INITIAL_CREDIT: window_reg = cfg_data;
          REG_PING_REPLY_ON:  ping_on = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy && sess_up) begin
        step_cnt = 0;
        case (cmd_t'(in_item.command))
          CMD_FRAME:   do_frame(in_item);
          CMD_SEND:    do_send(in_item.stream_number, in_item.frame_len);
          CMD_OUTCOME: do_outcome(in_item.stream_number, in_item.outcome);
          default:     do_release(in_item.stream_number, in_item.outcome);
        endcase
        for (int k = 0; k < step_cnt && k < 2; k++) begin
          want = step_buf[k];
          want.last = (k == step_cnt - 1);
          words_due.insert(words_due.size(), want);
        end
      end
    end
    pending_words = words_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import ysfc_pkg::*;

  localparam int HOLD_OFF   = 140;
  localparam int STALL_MAX  = 5000;
  localparam int PHASE_SIZE = 215;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending_words;

  logic        word_taken;
  logic        cfg_taken;
  logic        no_idle;
  int          stall_cycles;
  int          sent;

  yamux_stream_flow_control i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ysfc_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Handshakes are registered here so the driver can look at them on the
  // falling edge without racing the block.
  always @(posedge clk) begin
    word_taken <= start && !busy;
    cfg_taken <= cfg_valid && cfg_ready;
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t mk(cmd_t c, kind_t k, logic [3:0] fl, logic [31:0] s,
                                  logic [31:0] len, logic [1:0] oc);
    in_item_t it;
    it.command = c;
    it.frame_kind = k;
    it.frame_flags = fl;
    it.stream_number = s;
    it.frame_len = len;
    it.outcome = oc;
    return it;
  endfunction

  function automatic logic [31:0] pick_stream(int pool);
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(1, pool);
    if (r < 96) return $urandom();
    return 0;
  endfunction

  // Called on a falling edge; returns on the falling edge after acceptance, or on a later one after a random idle gap.
  task automatic issue(in_item_t it);
    in_item <= it;
    start <= 1'b1;
    do @(negedge clk); while (!word_taken);
    sent++;
    if (!no_idle && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits out every expected word, then the longest search an item without
  // a result can still be busy with.
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_words != 0 || busy) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  task automatic random_word(int pool);
    in_item_t it;
    int       r;
    it = mk(cmd_t'($urandom_range(0, 3)), kind_t'($urandom_range(0, 3)),
            4'($urandom_range(0, 15)), pick_stream(pool), 0, 2'($urandom_range(0, 3)));
    r = $urandom_range(0, 99);
    if (r < 50) it.frame_len = $urandom_range(0, 40);
    else if (r < 80) it.frame_len = $urandom();
    else it.frame_len = 32'hFFFF_FFFF - $urandom_range(0, 3);
    // Closing the session is left to the very end of the run.
    if (it.command == CMD_FRAME && it.frame_kind == KIND_GOAWAY) it.frame_kind = KIND_PING;
    if (it.command == CMD_FRAME && it.frame_kind == KIND_DATA) it.frame_len[31:16] = '0;
    issue(it);
  endtask

  // A stream's life: open, maybe address bytes, activation outcome, traffic, maybe close.
  task automatic stream_life(int pool);
    logic [31:0] s;
    in_item_t    it;
    logic [3:0]  syn;
    int          r;
    s = pick_stream(pool);
    syn = '0;
    syn[FLAG_SYN] = 1'b1;
    if ($urandom_range(0, 3) == 0)
      issue(mk(CMD_FRAME, KIND_WU, syn, s, ($urandom_range(0, 3) == 0) ? 0 : $urandom(), 0));
    else
      issue(mk(CMD_FRAME, KIND_DATA, syn, s, $urandom_range(0, 12), 0));
    if ($urandom_range(0, 1))
      issue(mk(CMD_FRAME, KIND_DATA, FL_NONE, s, $urandom_range(0, 10), 0));
    r = $urandom_range(0, 99);
    issue(mk(CMD_OUTCOME, KIND_DATA, FL_NONE, s, 0,
             (r < 75) ? OC_SUCCESS : (r < 88) ? OC_FAILURE : (r < 96) ? OC_MORE : 2'd3));
    repeat ($urandom_range(1, 5)) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        it = mk(CMD_FRAME, KIND_DATA, FL_NONE, s,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000),
                0);
      else if (r < 70)
        it = mk(CMD_SEND, KIND_DATA, FL_NONE, s,
                ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 500), 0);
      else if (r < 90)
        it = mk(CMD_FRAME, KIND_WU, FL_NONE, s,
                ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 100), 0);
      else
        it = mk(CMD_FRAME, KIND_PING, syn, 0, $urandom(), 0);
      issue(it);
    end
    r = $urandom_range(0, 4);
    case (r)
      0: issue(mk(CMD_FRAME, KIND_DATA, FL_FIN, s, 0, 0));
      1: issue(mk(CMD_FRAME, kind_t'($urandom_range(0, 1)), FL_RST, s, 0, 0));
      2: issue(mk(CMD_RELEASE, KIND_DATA, FL_NONE, s, 0, OC_SUCCESS));
      3: issue(mk(CMD_RELEASE, KIND_DATA, FL_NONE, s, 0, OC_FAILURE));
      default: ;
    endcase
  endtask

  initial begin
    logic [6:0]  lim_set   [6];
    logic [31:0] cred_set  [6];
    logic        ping_set  [6];
    logic [3:0]  syn;
    logic [3:0]  synack;
    int          pool;
    lim_set  = '{7'd64, 7'd3, 7'd0, 7'd127, 7'd64, 7'd1};
    cred_set = '{32'd262144, 32'd20, 32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd7};
    ping_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    syn = '0;
    syn[FLAG_SYN] = 1'b1;
    synack = syn | FL_ACK;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at the reset configuration.
    issue(mk(CMD_FRAME, KIND_PING, syn, 0, 32'hFFFF_FFFF, 0));
    issue(mk(CMD_FRAME, KIND_PING, FL_ACK, 0, 5, 0));
    issue(mk(CMD_FRAME, KIND_DATA, syn, 1, 7, 0));
    issue(mk(CMD_OUTCOME, KIND_DATA, FL_NONE, 1, 0, OC_SUCCESS));
    issue(mk(CMD_FRAME, KIND_DATA, FL_NONE, 1, 65535, 0));
    issue(mk(CMD_FRAME, KIND_DATA, FL_NONE, 1, 65535, 0));
    issue(mk(CMD_FRAME, KIND_DATA, FL_NONE, 1, 10, 0));
    issue(mk(CMD_FRAME, KIND_WU, FL_NONE, 1, 32'hFFFF_FFFF, 0));
    issue(mk(CMD_SEND, KIND_DATA, FL_NONE, 1, 5, 0));
    issue(mk(CMD_SEND, KIND_DATA, FL_NONE, 99, 32'hFFFF_FFFF, 0));
    issue(mk(CMD_FRAME, KIND_WU, syn, 2, 0, 0));
    issue(mk(CMD_SEND, KIND_DATA, FL_NONE, 2, 300000, 0));
    issue(mk(CMD_FRAME, KIND_DATA, syn, 2, 9, 0));
    issue(mk(CMD_FRAME, KIND_DATA, syn, 3, 3, 0));
    issue(mk(CMD_FRAME, KIND_DATA, FL_NONE, 3, 4, 0));
    issue(mk(CMD_OUTCOME, KIND_DATA, FL_NONE, 3, 0, OC_MORE));
    issue(mk(CMD_FRAME, KIND_DATA, FL_NONE, 3, 0, 0));
    issue(mk(CMD_OUTCOME, KIND_DATA, FL_NONE, 3, 0, 2'd3));
    issue(mk(CMD_OUTCOME, KIND_DATA, FL_NONE, 3, 0, OC_FAILURE));
    issue(mk(CMD_FRAME, KIND_DATA, FL_NONE, 77, 1, 0));
    issue(mk(CMD_FRAME, KIND_WU, FL_NONE, 0, 100, 0));
    issue(mk(CMD_FRAME, KIND_WU, synack, 4, 100, 0));
    issue(mk(CMD_FRAME, KIND_DATA, FL_FIN, 1, 0, 0));
    issue(mk(CMD_FRAME, KIND_WU, FL_RST, 1, 0, 0));
    issue(mk(CMD_RELEASE, KIND_DATA, FL_NONE, 2, 0, 2'd3));
    issue(mk(CMD_RELEASE, KIND_DATA, FL_NONE, 2, 0, OC_SUCCESS));

    for (int p = 0; p < 6; p++) begin
      settle();
      if (p != 0) begin
        write_reg(REG_STREAM_LIMIT, {25'd0, lim_set[p]});
        write_reg(REG_INITIAL_CREDIT, cred_set[p]);
        write_reg(REG_PING_REPLY_ON, {31'd0, ping_set[p]});
      end
      pool = (lim_set[p] >= 64) ? 80 : 10;
      no_idle = (p == 4);
      sent = 0;
      while (sent < PHASE_SIZE) begin
        if ($urandom_range(0, 99) < 70) stream_life(pool);
        else random_word(pool);
      end
    end

    // An oversize data frame closes the session; the GoAway after it is ignored.
    issue(mk(CMD_FRAME, KIND_DATA, FL_NONE, 5, 65536, 0));
    issue(mk(CMD_FRAME, KIND_GOAWAY, FL_NONE, 0, 0, 0));
    settle();
    if (fail_count == 0 && pending_words == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ysfc_pkg.sv
rtl/ysfc_datapath.sv
rtl/ysfc_ctrl.sv
rtl/yamux_stream_flow_control.sv
tb/ysfc_checker.sv
tb/tb_top.sv
